>>> src/ltp_pkg.sv
`timescale 1ns / 1ps

package ltp_pkg;

  // Integral state is held multiplied by this scale.
  localparam int INTEGRAL_SCALE = 500;

  // Turn divisor: gains are in hundredths and the integral is scaled.
  localparam logic [63:0] TURN_DIV = 64'(100 * INTEGRAL_SCALE);
  // Magnitudes at or above this value saturate the turn output.
  localparam logic [48:0] TURN_SAT_LIM = 49'(64'd32768 * TURN_DIV);
  // Reciprocal multiply for magnitudes below TURN_SAT_LIM (under 2^31).
  localparam int TURN_SHIFT = 47;
  localparam logic [31:0] TURN_RECIP =
    32'(((64'd1 << TURN_SHIFT) + TURN_DIV - 64'd1) / TURN_DIV);

  localparam logic signed [15:0] TURN_MAX = 16'sh7FFF;
  localparam logic signed [15:0] TURN_MIN = 16'sh8000;

  // Tail drive: divide by 100 and clamp to plus or minus 100.
  localparam int TAIL_DIV = 100;
  localparam int TAIL_LIMIT = 100;
  localparam logic [27:0] TAIL_SAT_LIM = 28'((TAIL_LIMIT + 1) * TAIL_DIV);
  localparam int TAIL_SHIFT = 21;
  localparam logic [14:0] TAIL_RECIP =
    15'(((32'd1 << TAIL_SHIFT) + TAIL_DIV - 1) / TAIL_DIV);
  localparam logic signed [7:0] TAIL_MAX = 8'(TAIL_LIMIT);
  localparam logic signed [7:0] TAIL_MIN = -8'(TAIL_LIMIT);

  // Accumulator limits for the saturating integral.
  localparam logic signed [33:0] ACC_MAX = 34'sd2147483647;
  localparam logic signed [33:0] ACC_MIN = -34'sd2147483648;

  // Trace mode codes; any other code behaves as hold.
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_TRACE  = 2'd1;
  localparam logic [1:0] MODE_HOLD   = 2'd2;

  typedef enum logic [2:0] {
    CFG_TRACE_MODE  = 3'd0,
    CFG_EDGE_LEVEL  = 3'd1,
    CFG_P_GAIN      = 3'd2,
    CFG_I_GAIN      = 3'd3,
    CFG_D_GAIN      = 3'd4,
    CFG_MANUAL_TURN = 3'd5,
    CFG_TAIL_TARGET = 3'd6,
    CFG_TAIL_GAIN   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]          light_sample;
    logic signed [15:0]  tail_count;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  turn_value;
    logic signed [7:0]   tail_drive;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          trace_mode;
    logic [9:0]          edge_level;
    logic signed [15:0]  p_gain;
    logic signed [15:0]  i_gain;
    logic signed [15:0]  d_gain;
    logic signed [7:0]   manual_turn;
    logic signed [15:0]  tail_target;
    logic [9:0]          tail_gain;
  } cfg_t;

  // Updated controller state handed to the pipeline.
  typedef struct packed {
    logic                manual;
    logic signed [10:0]  e_now;
    logic signed [11:0]  diff;
    logic signed [31:0]  integ;
  } err_upd_t;

  // Load enables of the pipeline stages after stage two.
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  typedef struct packed {
    logic        manual;
    logic        sat;
    logic        neg;
    logic [14:0] q;
  } turn_res_t;

  typedef struct packed {
    logic       sat;
    logic       neg;
    logic [6:0] q;
  } tail_res_t;

endpackage

>>> src/ltp_cfg_regs.sv
`timescale 1ns / 1ps

module ltp_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata,
  output ltp_pkg::cfg_t       cfg
);

  ltp_pkg::cfg_t cfg_r;

  // Register file with reset values; writes are truncated to each width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trace_mode  <= ltp_pkg::MODE_MANUAL;
      cfg_r.edge_level  <= 10'd600;
      cfg_r.p_gain      <= 16'sd100;
      cfg_r.i_gain      <= 16'sd0;
      cfg_r.d_gain      <= 16'sd0;
      cfg_r.manual_turn <= 8'sd0;
      cfg_r.tail_target <= 16'sd0;
      cfg_r.tail_gain   <= 10'd80;
    end else if (cfg_we) begin
      unique case (ltp_pkg::cfg_idx_t'(cfg_addr))
        ltp_pkg::CFG_TRACE_MODE:  cfg_r.trace_mode  <= cfg_wdata[1:0];
        ltp_pkg::CFG_EDGE_LEVEL:  cfg_r.edge_level  <= cfg_wdata[9:0];
        ltp_pkg::CFG_P_GAIN:      cfg_r.p_gain      <= cfg_wdata;
        ltp_pkg::CFG_I_GAIN:      cfg_r.i_gain      <= cfg_wdata;
        ltp_pkg::CFG_D_GAIN:      cfg_r.d_gain      <= cfg_wdata;
        ltp_pkg::CFG_MANUAL_TURN: cfg_r.manual_turn <= cfg_wdata[7:0];
        ltp_pkg::CFG_TAIL_TARGET: cfg_r.tail_target <= cfg_wdata;
        ltp_pkg::CFG_TAIL_GAIN:   cfg_r.tail_gain   <= cfg_wdata[9:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/ltp_err_state.sv
`timescale 1ns / 1ps

module ltp_err_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd,
  input  logic [9:0]          light_sample,
  input  logic [1:0]          trace_mode,
  input  logic [9:0]          edge_level,
  output ltp_pkg::err_upd_t   err_upd
);

  logic signed [10:0] error_now_r;
  logic signed [10:0] error_last_r;
  logic signed [31:0] integ_r;

  logic signed [10:0] error_now_nxt;
  logic signed [10:0] error_last_nxt;
  logic signed [31:0] integ_nxt;
  logic signed [33:0] acc;
  logic               is_manual;

  assign is_manual = (trace_mode == ltp_pkg::MODE_MANUAL);

  // Error update: trace takes a new sample, hold keeps the current error.
  always_comb begin
    error_last_nxt = error_now_r;
    if (trace_mode == ltp_pkg::MODE_TRACE) begin
      error_now_nxt = signed'(11'({1'b0, light_sample}) - 11'({1'b0, edge_level}));
    end else begin
      error_now_nxt = error_now_r;
    end
    acc = 34'(integ_r) + 34'(error_now_nxt) + 34'(error_last_nxt);
    priority if (acc > ltp_pkg::ACC_MAX) begin
      integ_nxt = 32'(ltp_pkg::ACC_MAX);
    end else if (acc < ltp_pkg::ACC_MIN) begin
      integ_nxt = 32'(ltp_pkg::ACC_MIN);
    end else begin
      integ_nxt = 32'(acc);
    end
  end

  // State registers advance once per transaction outside manual mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_now_r  <= '0;
      error_last_r <= '0;
      integ_r      <= '0;
    end else if (upd && !is_manual) begin
      error_now_r  <= error_now_nxt;
      error_last_r <= error_last_nxt;
      integ_r      <= integ_nxt;
    end
  end

  assign err_upd.manual = is_manual;
  assign err_upd.e_now  = error_now_nxt;
  assign err_upd.diff   = 12'(error_now_nxt) - 12'(error_last_nxt);
  assign err_upd.integ  = integ_nxt;

`ifndef SYNTHESIS
  // Manual mode leaves the controller state untouched.
  a_manual_holds: assert property (@(posedge clk) disable iff (!rst_n)
    upd && is_manual |=> $stable(integ_r) && $stable(error_now_r)
      && $stable(error_last_r))
    else $error("controller state changed in manual mode");

  // Hold mode copies the error into the previous error and keeps it.
  a_hold_copies: assert property (@(posedge clk) disable iff (!rst_n)
    upd && !is_manual && trace_mode != ltp_pkg::MODE_TRACE
      |=> $stable(error_now_r) && error_last_r == error_now_r)
    else $error("hold mode did not freeze the error");
`endif

endmodule

>>> src/ltp_turn_pipe.sv
`timescale 1ns / 1ps

module ltp_turn_pipe (
  input  logic                  clk,
  input  ltp_pkg::stage_en_t    en,
  input  logic                  manual,
  input  logic signed [10:0]    e_now,
  input  logic signed [11:0]    diff,
  input  logic signed [31:0]    integ,
  input  logic signed [15:0]    p_gain,
  input  logic signed [15:0]    i_gain,
  input  logic signed [15:0]    d_gain,
  output ltp_pkg::turn_res_t    turn_res
);

  logic signed [26:0] s3_pe_r;
  logic signed [27:0] s3_dd_r;
  logic signed [47:0] s3_ii_r;
  logic               s3_manual_r;

  logic signed [48:0] s4_num_r;
  logic               s4_manual_r;

  logic [30:0]        s5_mag_r;
  logic               s5_sat_r;
  logic               s5_neg_r;
  logic               s5_manual_r;

  ltp_pkg::turn_res_t s6_r;

  logic signed [28:0] pd_sum;
  logic [48:0]        num_abs;
  logic [62:0]        recip_prod;

  assign pd_sum = 29'(s3_pe_r) + 29'(s3_dd_r);
  assign num_abs = s4_num_r[48] ? 49'(-s4_num_r) : 49'(s4_num_r);
  assign recip_prod = 63'(s5_mag_r) * 63'(ltp_pkg::TURN_RECIP);

  // Stage three: the three gain products.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_pe_r     <= 27'(p_gain) * 27'(e_now);
      s3_dd_r     <= 28'(d_gain) * 28'(diff);
      s3_ii_r     <= 48'(i_gain) * 48'(integ);
      s3_manual_r <= manual;
    end
  end

  // Stage four: scaled numerator.
  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4_num_r    <= 49'(pd_sum) * 49'(ltp_pkg::INTEGRAL_SCALE) + 49'(s3_ii_r);
      s4_manual_r <= s3_manual_r;
    end
  end

  // Stage five: sign, magnitude and saturation check.
  always_ff @(posedge clk) begin
    if (en.s5) begin
      s5_mag_r    <= num_abs[30:0];
      s5_sat_r    <= (num_abs >= ltp_pkg::TURN_SAT_LIM);
      s5_neg_r    <= s4_num_r[48];
      s5_manual_r <= s4_manual_r;
    end
  end

  // Stage six: quotient by reciprocal multiply.
  always_ff @(posedge clk) begin
    if (en.s6) begin
      s6_r.q      <= recip_prod[ltp_pkg::TURN_SHIFT + 14 : ltp_pkg::TURN_SHIFT];
      s6_r.sat    <= s5_sat_r;
      s6_r.neg    <= s5_neg_r;
      s6_r.manual <= s5_manual_r;
    end
  end

  assign turn_res = s6_r;

endmodule

>>> src/ltp_tail_pipe.sv
`timescale 1ns / 1ps

module ltp_tail_pipe (
  input  logic                  clk,
  input  ltp_pkg::stage_en_t    en,
  input  logic signed [16:0]    tail_err,
  input  logic [9:0]            tail_gain,
  output ltp_pkg::tail_res_t    tail_res
);

  logic signed [27:0] s3_prod_r;
  logic [13:0]        s4_mag_r;
  logic               s4_sat_r;
  logic               s4_neg_r;
  ltp_pkg::tail_res_t s5_r;
  ltp_pkg::tail_res_t s6_r;

  logic [27:0]        prod_abs;
  logic [28:0]        recip_prod;

  assign prod_abs = s3_prod_r[27] ? 28'(-s3_prod_r) : 28'(s3_prod_r);
  assign recip_prod = 29'(s4_mag_r) * 29'(ltp_pkg::TAIL_RECIP);

  // Stage three: gain times position error.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_prod_r <= 28'(signed'({1'b0, tail_gain})) * 28'(tail_err);
    end
  end

  // Stage four: magnitude and clamp check on the full-width product.
  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4_mag_r <= prod_abs[13:0];
      s4_sat_r <= (prod_abs >= ltp_pkg::TAIL_SAT_LIM);
      s4_neg_r <= s3_prod_r[27];
    end
  end

  // Stage five: divide by 100 through a reciprocal multiply.
  always_ff @(posedge clk) begin
    if (en.s5) begin
      s5_r.q   <= recip_prod[ltp_pkg::TAIL_SHIFT + 6 : ltp_pkg::TAIL_SHIFT];
      s5_r.sat <= s4_sat_r;
      s5_r.neg <= s4_neg_r;
    end
  end

  // Stage six: keep in step with the turn path.
  always_ff @(posedge clk) begin
    if (en.s6) begin
      s6_r <= s5_r;
    end
  end

  assign tail_res = s6_r;

endmodule

>>> src/line_trace_pid_with_tail_clamp.sv
`timescale 1ns / 1ps

// Line-trace PID steering with a clamped proportional tail drive. The block
// takes one transaction per clock unless out_stall holds a full pipeline,
// and passes it through seven register stages (input register, state update,
// gain products, numerator, magnitude, reciprocal divide, output register).
// The error and saturating integral are updated as each item leaves the input
// register, so back-to-back items see each other's state; the remaining
// stages are a stallable pipeline whose bubbles are filled, so input is still
// taken while a finished result waits on out_stall, as long as a stage is
// empty. Write the configuration registers only while no transaction is in
// flight.
module line_trace_pid_with_tail_clamp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ltp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ltp_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata
);

  ltp_pkg::cfg_t      cfg;
  ltp_pkg::err_upd_t  err_upd;
  ltp_pkg::stage_en_t en;
  ltp_pkg::turn_res_t turn_res;
  ltp_pkg::tail_res_t tail_res;

  ltp_pkg::in_item_t  s1_r;
  logic               s2_manual_r;
  logic signed [10:0] s2_e_now_r;
  logic signed [11:0] s2_diff_r;
  logic signed [31:0] s2_integ_r;
  logic signed [16:0] s2_tail_err_r;
  ltp_pkg::out_item_t out_r;
  ltp_pkg::out_item_t out_nxt;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld_out;

  // A stage loads when it is empty or its contents move on.
  assign ld_out = !out_valid_r || !out_stall;
  assign ld6 = !v6_r || ld_out;
  assign ld5 = !v5_r || ld6;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign in_stall = !ld1;
  assign en.s3 = ld3;
  assign en.s4 = ld4;
  assign en.s5 = ld5;
  assign en.s6 = ld6;

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
      if (ld6) v6_r <= v5_r;
      if (ld_out) out_valid_r <= v6_r;
    end
  end

  ltp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_r <= in_data;
    end
  end

  ltp_err_state u_err (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (v1_r && ld2),
    .light_sample (s1_r.light_sample),
    .trace_mode   (cfg.trace_mode),
    .edge_level   (cfg.edge_level),
    .err_upd      (err_upd)
  );

  // Stage two: updated error terms and tail position error.
  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_manual_r   <= err_upd.manual;
      s2_e_now_r    <= err_upd.e_now;
      s2_diff_r     <= err_upd.diff;
      s2_integ_r    <= err_upd.integ;
      s2_tail_err_r <= 17'(cfg.tail_target) - 17'(s1_r.tail_count);
    end
  end

  ltp_turn_pipe u_turn (
    .clk      (clk),
    .en       (en),
    .manual   (s2_manual_r),
    .e_now    (s2_e_now_r),
    .diff     (s2_diff_r),
    .integ    (s2_integ_r),
    .p_gain   (cfg.p_gain),
    .i_gain   (cfg.i_gain),
    .d_gain   (cfg.d_gain),
    .turn_res (turn_res)
  );

  ltp_tail_pipe u_tail (
    .clk       (clk),
    .en        (en),
    .tail_err  (s2_tail_err_r),
    .tail_gain (cfg.tail_gain),
    .tail_res  (tail_res)
  );

  // Final sign, saturation and manual selection.
  always_comb begin
    priority if (turn_res.manual) begin
      out_nxt.turn_value = 16'(cfg.manual_turn);
    end else if (turn_res.sat) begin
      out_nxt.turn_value = turn_res.neg ? ltp_pkg::TURN_MIN : ltp_pkg::TURN_MAX;
    end else begin
      out_nxt.turn_value = turn_res.neg ? -16'(turn_res.q) : 16'(turn_res.q);
    end
    priority if (tail_res.sat) begin
      out_nxt.tail_drive = tail_res.neg ? ltp_pkg::TAIL_MIN : ltp_pkg::TAIL_MAX;
    end else begin
      out_nxt.tail_drive = tail_res.neg ? -8'(tail_res.q) : 8'(tail_res.q);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // The tail drive never leaves its clamp range.
  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.tail_drive >= ltp_pkg::TAIL_MIN
      && out_r.tail_drive <= ltp_pkg::TAIL_MAX)
    else $error("tail drive outside clamp range");

  // A new result only appears when the last stage held one.
  a_out_from_s6: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v6_r))
    else $error("result presented without a finished transaction");
`endif

endmodule
